// ===== hw/rtl/pbrq_pkg.sv =====
// ----------------------------------------------------------------------------
// pbrq_pkg: shared types and codes for the priority bucket run queue
// Opcodes and sequencer states used by the run queue modules.
// ----------------------------------------------------------------------------
package pbrq_pkg;

	localparam int OP_W = 3;
	localparam int TID_W = 31;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 3'd0,
		OP_DELETE   = 3'd1,
		OP_REINSERT = 3'd2,
		OP_ROTATE   = 3'd3,
		OP_PEEK     = 3'd4,
		OP_SEARCH   = 3'd5,
		OP_RSV6     = 3'd6,
		OP_RSV7     = 3'd7
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_UNLINK,
		ST_SCAN,
		ST_LINK,
		ST_HEADFIX,
		ST_SEARCH_LV,
		ST_SEARCH_SL,
		ST_DONE
	} state_t;

endpackage

// ===== hw/rtl/priority_bucket_run_queue_unit.sv =====
// ----------------------------------------------------------------------------
// priority_bucket_run_queue_unit: bucket priority run queue
// Per-level circular doubly linked rings of task slots, with a head register,
// sequenced one memory step per cycle.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Fields
// in       in   valid / ready        opcode slot priority_req task_id
// out      out  out_valid/out_ready  status head_valid head_slot head_priority
//                                    found found_slot
// Each item passes through the dispatch and done states; insert and delete add
// an unlink or link step, and a reinsert of a queued slot adds both.
// A delete or reinsert of the head whose level empties adds a scan of the lower levels.
// A search adds a step per level visited and one per slot compared.
// Reset clears the queued and nonempty flags and the head register at once.
// The next item is taken once the result register has been emptied.
// ----------------------------------------------------------------------------
module priority_bucket_run_queue_unit #(
	parameter int NUM_SLOTS  = 64,
	parameter int NUM_LEVELS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [2:0]  opcode,
	input  logic [5:0]  slot,
	input  logic [4:0]  priority_req,
	input  logic [30:0] task_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic        head_valid,
	output logic [5:0]  head_slot,
	output logic [4:0]  head_priority,
	output logic        found,
	output logic [5:0]  found_slot
);
	import pbrq_pkg::*;

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

	logic [SW-1:0] nxt_q [NUM_SLOTS];
	logic [SW-1:0] prv_q [NUM_SLOTS];
	logic [LW-1:0] lvl_q [NUM_SLOTS];
	logic [TID_W-1:0] tid_q [NUM_SLOTS];
	logic [SW-1:0] front_q [NUM_LEVELS];
	logic [SW-1:0] back_q [NUM_LEVELS];
	logic [NUM_SLOTS-1:0] queued_q;
	logic [NUM_LEVELS-1:0] nonempty_q;
	logic hv_q;
	logic [SW-1:0] hs_q;
	logic [LW-1:0] hl_q;

	state_t st_q;
	opcode_t op_q;
	logic ok_q;
	logic [SW-1:0] s_q;
	logic [LW-1:0] lv_q;
	logic [TID_W-1:0] key_q;
	logic [LW-1:0] i_q;
	logic [SW-1:0] cur_q;
	logic [SW:0] steps_q;
	logic st_res_q, fnd_q;
	logic [SW-1:0] fs_q;

	// Registered read data of the slot memories.
	logic [SW-1:0] nxt_rd_q, prv_rd_q;
	logic [LW-1:0] lvl_rd_q;
	logic [TID_W-1:0] tid_rd_q;

	logic [SW-1:0] s_n, pv, s_in;
	logic [LW-1:0] ul_lv;

	logic wide_slot, wide_lv;
	assign wide_slot = ({26'd0, slot} < 32'(NUM_SLOTS));
	assign wide_lv = ({27'd0, priority_req} >= 32'(NUM_LEVELS));
	assign s_in = wide_slot ? SW'(slot) : '0;

	assign ready = (st_q == ST_IDLE) && !out_valid;
	assign s_n = nxt_rd_q;
	assign pv = prv_rd_q;
	assign ul_lv = lvl_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			queued_q <= '0;
			nonempty_q <= '0;
			hv_q <= 1'b0;
			hs_q <= '0;
			hl_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (valid && ready) begin
						op_q <= opcode_t'(opcode);
						ok_q <= wide_slot;
						s_q <= s_in;
						lv_q <= wide_lv ? LW'(NUM_LEVELS - 1) : LW'(priority_req);
						key_q <= task_id;
						st_res_q <= 1'b0;
						fnd_q <= 1'b0;
						fs_q <= '0;
						// A rotate needs the successor of the head, all else the links of the slot.
						nxt_rd_q <= nxt_q[(opcode_t'(opcode) == OP_ROTATE) ? hs_q : s_in];
						prv_rd_q <= prv_q[s_in];
						lvl_rd_q <= lvl_q[s_in];
						st_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					st_q <= ST_DONE;
					case (op_q)
						OP_INSERT: begin
							if (!ok_q || queued_q[s_q]) st_res_q <= 1'b1;
							else begin
								tid_q[s_q] <= key_q;
								st_q <= ST_LINK;
							end
						end
						OP_DELETE: begin
							if (!ok_q || !queued_q[s_q]) st_res_q <= 1'b1;
							else st_q <= ST_UNLINK;
						end
						OP_REINSERT: begin
							if (!ok_q) st_res_q <= 1'b1;
							else if (queued_q[s_q]) st_q <= ST_UNLINK;
							else begin
								tid_q[s_q] <= key_q;
								st_q <= ST_LINK;
							end
						end
						OP_ROTATE: begin
							if (hv_q && nxt_rd_q != hs_q) begin
								back_q[hl_q] <= hs_q;
								front_q[hl_q] <= nxt_rd_q;
								hs_q <= nxt_rd_q;
							end
						end
						OP_SEARCH: begin
							i_q <= hv_q ? hl_q : '0;
							st_q <= ST_SEARCH_LV;
						end
						default: ;
					endcase
				end
				ST_UNLINK: begin
					prv_q[s_n] <= pv;
					nxt_q[pv] <= s_n;
					queued_q[s_q] <= 1'b0;
					st_q <= (op_q == OP_REINSERT) ? ST_LINK : ST_DONE;
					if (front_q[ul_lv] == s_q) begin
						if (s_n == s_q) nonempty_q[ul_lv] <= 1'b0;
						else front_q[ul_lv] <= s_n;
						if (hv_q && hs_q == s_q) begin
							if (s_n != s_q) hs_q <= s_n;
							else begin
								hv_q <= 1'b0;
								hs_q <= '0;
								i_q <= ul_lv;
								if (32'(ul_lv) + 1 < 32'(NUM_LEVELS)) st_q <= ST_SCAN;
							end
						end
					end else if (back_q[ul_lv] == s_q) begin
						back_q[ul_lv] <= pv;
					end
				end
				ST_SCAN: begin
					// Walk levels below the emptied one, one per cycle.
					if (nonempty_q[i_q + 1'b1]) begin
						hv_q <= 1'b1;
						hs_q <= front_q[i_q + 1'b1];
						hl_q <= i_q + 1'b1;
						st_q <= (op_q == OP_REINSERT) ? ST_LINK : ST_DONE;
					end else if (32'(i_q) + 2 >= 32'(NUM_LEVELS)) begin
						st_q <= (op_q == OP_REINSERT) ? ST_LINK : ST_DONE;
					end
					i_q <= i_q + 1'b1;
				end
				ST_LINK: begin
					lvl_q[s_q] <= lv_q;
					queued_q[s_q] <= 1'b1;
					st_q <= ST_DONE;
					if (!nonempty_q[lv_q]) begin
						nxt_q[s_q] <= s_q;
						prv_q[s_q] <= s_q;
						front_q[lv_q] <= s_q;
						back_q[lv_q] <= s_q;
						nonempty_q[lv_q] <= 1'b1;
						if (!hv_q || lv_q < hl_q) begin
							hv_q <= 1'b1;
							hs_q <= s_q;
							hl_q <= lv_q;
						end
					end else begin
						prv_q[front_q[lv_q]] <= s_q;
						nxt_q[s_q] <= front_q[lv_q];
						prv_q[s_q] <= back_q[lv_q];
						nxt_q[back_q[lv_q]] <= s_q;
						back_q[lv_q] <= s_q;
					end
				end
				ST_SEARCH_LV: begin
					if (nonempty_q[i_q]) begin
						cur_q <= front_q[i_q];
						tid_rd_q <= tid_q[front_q[i_q]];
						nxt_rd_q <= nxt_q[front_q[i_q]];
						steps_q <= '0;
						st_q <= ST_SEARCH_SL;
					end else if (32'(i_q) + 1 >= 32'(NUM_LEVELS)) st_q <= ST_DONE;
					else i_q <= i_q + 1'b1;
				end
				ST_SEARCH_SL: begin
					if (tid_rd_q == key_q) begin
						fnd_q <= 1'b1;
						fs_q <= cur_q;
						st_q <= ST_DONE;
					end else if (nxt_rd_q == front_q[i_q]
							|| 32'(steps_q) + 1 >= 32'(NUM_SLOTS)) begin
						if (32'(i_q) + 1 >= 32'(NUM_LEVELS)) st_q <= ST_DONE;
						else begin
							i_q <= i_q + 1'b1;
							st_q <= ST_SEARCH_LV;
						end
					end else begin
						cur_q <= nxt_rd_q;
						tid_rd_q <= tid_q[nxt_rd_q];
						nxt_rd_q <= nxt_q[nxt_rd_q];
						steps_q <= steps_q + 1'b1;
					end
				end
				ST_DONE: begin
					status <= st_res_q;
					head_valid <= hv_q;
					head_slot <= hv_q ? 6'(hs_q) : 6'd0;
					head_priority <= hv_q ? 5'(hl_q) : 5'd0;
					found <= fnd_q;
					found_slot <= fnd_q ? 6'(fs_q) : 6'd0;
					out_valid <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
